>>> hw/rtl/scis_pkg.sv
// scis_pkg: shared constants and helpers for the stack cpu instruction step block
// instruction field codes, console addresses and stack pointer arithmetic
// no dependencies
package scis_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned SP_W        = 5;

  localparam logic [31:0] IO_DATA   = 32'hf000_0000;
  localparam logic [31:0] IO_STATUS = 32'hf000_0001;

  // instruction forms, bits 30:29 when bit 31 is clear
  localparam logic [1:0] FORM_JUMP  = 2'd0;
  localparam logic [1:0] FORM_CJUMP = 2'd1;
  localparam logic [1:0] FORM_CALL  = 2'd2;
  localparam logic [1:0] FORM_ALU   = 2'd3;

  // alu operations, bits 11:8
  localparam logic [3:0] ALU_T      = 4'h0;
  localparam logic [3:0] ALU_N      = 4'h1;
  localparam logic [3:0] ALU_ADD    = 4'h2;
  localparam logic [3:0] ALU_AND    = 4'h3;
  localparam logic [3:0] ALU_OR     = 4'h4;
  localparam logic [3:0] ALU_XOR    = 4'h5;
  localparam logic [3:0] ALU_INV    = 4'h6;
  localparam logic [3:0] ALU_EQ     = 4'h7;
  localparam logic [3:0] ALU_SLT    = 4'h8;
  localparam logic [3:0] ALU_SHR    = 4'h9;
  localparam logic [3:0] ALU_DEC    = 4'ha;
  localparam logic [3:0] ALU_R      = 4'hb;
  localparam logic [3:0] ALU_LOAD   = 4'hc;
  localparam logic [3:0] ALU_SHL    = 4'hd;
  localparam logic [3:0] ALU_DEPTH  = 4'he;
  localparam logic [3:0] ALU_ULT    = 4'hf;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic [SP_W-1:0] sp_t;

  // two-bit stack delta code: 0, +1, -2, -1
  function automatic sp_t stack_delta(input logic [1:0] code);
    sp_t d;
    case (code)
      2'd0:    d = sp_t'(0);
      2'd1:    d = sp_t'(1);
      2'd2:    d = sp_t'(STACK_DEPTH - 2);
      default: d = sp_t'(STACK_DEPTH - 1);
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/stack_cpu_instruction_step_top.sv
// stack_cpu_instruction_step_top: 32-bit dual-stack cpu core, one instruction per step item
// word memory with two read ports and one write port, stacks in flops; uses scis_pkg
//
// channel  | direction | payload
// in_      | input     | op, load_addr, load_data, rx_byte
// out_     | output    | next_pc, top_value, tx_valid, tx_byte, rx_taken
//
// each item is accepted, which reads memory at pc and at the top of stack, then
// executed and written back; a new item is not taken until the previous one has
// executed. after reset a clearing pass zeroes the memory with in_stall high.
// out_stall holds the execute stage; one item may still be accepted while a
// result waits. MEM_DEPTH must be a power of two; the block does not check it.
module stack_cpu_instruction_step_top
  import scis_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [14:0] in_load_addr,
  input  logic [31:0] in_load_data,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_next_pc,
  output logic [31:0] out_top_value,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_rx_taken
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // word memory
  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] insn_q;
  logic [31:0] rdata_q;

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // cpu state
  logic [AW-1:0] pc_r, pc_nxt;
  logic [31:0]   top_r, top_nxt;
  sp_t           dp_r, dp_nxt;
  sp_t           rp_r, rp_nxt;
  logic [31:0]   dstk_r [STACK_DEPTH];
  logic [31:0]   rstk_r [STACK_DEPTH];

  // execute stage
  logic          ex_valid_r;
  logic          ex_op_r;
  logic [14:0]   ex_load_addr_r;
  logic [31:0]   ex_load_data_r;
  logic [7:0]    ex_rx_r;

  // output register
  logic          out_valid_r;
  logic [14:0]   out_next_pc_r;
  logic [31:0]   out_top_r;
  logic          out_tx_valid_r;
  logic [7:0]    out_tx_byte_r;
  logic          out_rx_taken_r;

  logic in_xfer, ex_fire;

  assign in_stall = ex_valid_r | clr_busy_r;
  assign in_xfer  = in_valid & ~in_stall;
  assign ex_fire  = ex_valid_r & (~out_valid_r | ~out_stall);

  // execute logic
  logic [31:0]   t, n, r;
  logic [AW-1:0] npc, target;
  logic [AW-1:0] t_idx, ld_idx;
  logic [31:0]   ld_ext, pc_ext;
  logic [31:0]   alu_res;
  logic          dwe, rwe, mwe;
  sp_t           dw_addr, rw_addr;
  logic [31:0]   dw_data, rw_data;
  logic [AW-1:0] mw_addr;
  logic [31:0]   mw_data;
  logic          tx_valid, rx_taken;
  logic [7:0]    tx_byte;

  assign t      = top_r;
  assign n      = dstk_r[dp_r];
  assign r      = rstk_r[rp_r];
  assign npc    = pc_r + AW'(1);
  assign target = insn_q[AW-1:0];
  assign t_idx  = t[AW+1:2];
  assign ld_ext = 32'(ex_load_addr_r);
  assign ld_idx = ld_ext[AW-1:0];

  always_comb begin
    alu_res  = t;
    rx_taken = 1'b0;
    case (insn_q[11:8])
      ALU_T:     alu_res = t;
      ALU_N:     alu_res = n;
      ALU_ADD:   alu_res = t + n;
      ALU_AND:   alu_res = t & n;
      ALU_OR:    alu_res = t | n;
      ALU_XOR:   alu_res = t ^ n;
      ALU_INV:   alu_res = ~t;
      ALU_EQ:    alu_res = {32{t == n}};
      ALU_SLT:   alu_res = {32{$signed(n) < $signed(t)}};
      ALU_SHR:   alu_res = (t < 32'd32) ? (n >> t[4:0]) : 32'd0;
      ALU_DEC:   alu_res = t - 32'd1;
      ALU_R:     alu_res = r;
      ALU_LOAD: begin
        if (t == IO_STATUS) begin
          alu_res = 32'd1;
        end else if (t == IO_DATA) begin
          alu_res  = 32'(ex_rx_r);
          rx_taken = 1'b1;
        end else begin
          alu_res = rdata_q;
        end
      end
      ALU_SHL:   alu_res = (t < 32'd32) ? (n << t[4:0]) : 32'd0;
      ALU_DEPTH: alu_res = {19'd0, rp_r, 3'd0, dp_r};
      ALU_ULT:   alu_res = {32{n < t}};
      default:   alu_res = t;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    top_nxt  = top_r;
    dp_nxt   = dp_r;
    rp_nxt   = rp_r;
    dwe      = 1'b0;
    dw_addr  = dp_r;
    dw_data  = t;
    rwe      = 1'b0;
    rw_addr  = rp_r;
    rw_data  = t;
    mwe      = 1'b0;
    mw_addr  = t_idx;
    mw_data  = n;
    tx_valid = 1'b0;
    tx_byte  = 8'd0;
    if (ex_op_r == OP_LOAD) begin
      mwe     = 1'b1;
      mw_addr = ld_idx;
      mw_data = ex_load_data_r;
    end else begin
      pc_nxt = npc;
      if (insn_q[31]) begin
        // literal push
        dp_nxt  = dp_r + sp_t'(1);
        dwe     = 1'b1;
        dw_addr = dp_r + sp_t'(1);
        top_nxt = {1'b0, insn_q[30:0]};
      end else begin
        case (insn_q[30:29])
          FORM_JUMP: pc_nxt = target;
          FORM_CJUMP: begin
            top_nxt = n;
            dp_nxt  = dp_r - sp_t'(1);
            if (t == 32'd0) pc_nxt = target;
          end
          FORM_CALL: begin
            rp_nxt  = rp_r + sp_t'(1);
            rwe     = 1'b1;
            rw_addr = rp_r + sp_t'(1);
            rw_data = 32'({npc, 2'b00});
            pc_nxt  = target;
          end
          FORM_ALU: begin
            if (insn_q[12]) pc_nxt = r[AW+1:2];
            top_nxt = alu_res;
            dp_nxt  = dp_r + stack_delta(insn_q[1:0]);
            rp_nxt  = rp_r + stack_delta(insn_q[3:2]);
            dwe     = insn_q[7];
            dw_addr = dp_r + stack_delta(insn_q[1:0]);
            rwe     = insn_q[6];
            rw_addr = rp_r + stack_delta(insn_q[3:2]);
            if (insn_q[5]) begin
              if (t == IO_DATA) begin
                tx_valid = 1'b1;
                tx_byte  = n[7:0];
              end else begin
                mwe = 1'b1;
              end
            end
          end
          default: pc_nxt = npc;
        endcase
      end
    end
  end

  assign pc_ext = 32'(pc_nxt);

  // memory: reads on input transfer, writes from execute or the clearing pass
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= 32'd0;
    end else if (ex_fire && mwe) begin
      mem[mw_addr] <= mw_data;
    end
    if (in_xfer) begin
      insn_q  <= mem[pc_r];
      rdata_q <= mem[t_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MEM_DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  // cpu state and stacks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      top_r <= '0;
      dp_r  <= '0;
      rp_r  <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        dstk_r[i] <= '0;
        rstk_r[i] <= '0;
      end
    end else if (ex_fire) begin
      pc_r  <= pc_nxt;
      top_r <= top_nxt;
      dp_r  <= dp_nxt;
      rp_r  <= rp_nxt;
      if (dwe) dstk_r[dw_addr] <= dw_data;
      if (rwe) rstk_r[rw_addr] <= rw_data;
    end
  end

  // execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_xfer) begin
      ex_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ex_op_r        <= in_op;
      ex_load_addr_r <= in_load_addr;
      ex_load_data_r <= in_load_data;
      ex_rx_r        <= in_rx_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_next_pc_r  <= pc_ext[14:0];
      out_top_r      <= top_nxt;
      out_tx_valid_r <= tx_valid;
      out_tx_byte_r  <= tx_byte;
      out_rx_taken_r <= (ex_op_r == OP_STEP) && !insn_q[31] &&
                        (insn_q[30:29] == FORM_ALU) && rx_taken;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_pc   = out_next_pc_r;
  assign out_top_value = out_top_r;
  assign out_tx_valid  = out_tx_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_rx_taken  = out_rx_taken_r;

endmodule

>>> test/stack_cpu_instruction_step_top_test.sv
// stack_cpu_instruction_step_top_test: self-checking bench for the stack cpu step block
// loads program words, steps the core and checks every result against an in-bench cpu model
// depends on scis_pkg and stack_cpu_instruction_step_top
module stack_cpu_instruction_step_top_test;
  import scis_pkg::*;

  localparam int MEM_WORDS   = 32768;
  localparam int ITEM_GOAL   = 1050;
  localparam int DRAIN_TAIL  = 12;
  localparam int HOLD_CYCLES = 150;
  localparam int RUN_LIMIT   = 12 * 600000;

  // alu instruction bit positions
  localparam int RPC_BIT   = 12;
  localparam int TN_BIT    = 7;
  localparam int TR_BIT    = 6;
  localparam int STORE_BIT = 5;

  // stack delta codes
  localparam bit [1:0] DELTA_NONE = 2'd0;
  localparam bit [1:0] DELTA_PUSH = 2'd1;
  localparam bit [1:0] DELTA_POP2 = 2'd2;
  localparam bit [1:0] DELTA_POP  = 2'd3;

  typedef struct packed {
    logic [14:0] pc;
    logic [31:0] top;
    logic        txv;
    logic [7:0]  txb;
    logic        rxt;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_LOAD;
  logic [14:0] in_load_addr = '0;
  logic [31:0] in_load_data = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_next_pc;
  logic [31:0] out_top_value;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_rx_taken;

  // cpu model state
  bit [14:0] cpu_pc;
  bit [31:0] cpu_t;
  bit [31:0] dstk [32];
  bit [31:0] rstk [32];
  bit [4:0]  dsp;
  bit [4:0]  rsp;
  bit [31:0] mem_img [MEM_WORDS];

  step_result_t expected_q [$];
  step_result_t head_result;

  int mismatches   = 0;
  int items_sent   = 0;
  int sink_gap     = 0;
  bit hold_go      = 1'b0;
  bit sink_hold    = 1'b0;
  bit feed_steady  = 1'b0;
  bit drain_steady = 1'b0;

  stack_cpu_instruction_step_top #(.MEM_DEPTH(MEM_WORDS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_load_addr (in_load_addr),
    .in_load_data (in_load_data),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_next_pc  (out_next_pc),
    .out_top_value(out_top_value),
    .out_tx_valid (out_tx_valid),
    .out_tx_byte  (out_tx_byte),
    .out_rx_taken (out_rx_taken)
  );

  always #6 clk = ~clk;

  function automatic bit [4:0] ptr_step(input bit [1:0] code);
    case (code)
      DELTA_PUSH: return 5'd1;
      DELTA_POP2: return 5'd30;
      DELTA_POP:  return 5'd31;
      default:    return 5'd0;
    endcase
  endfunction

  // advances the cpu model by one transfer and returns the result it should give
  function automatic step_result_t cpu_model(input logic op, input logic [14:0] la,
                                             input logic [31:0] ld, input logic [7:0] rx);
    step_result_t res;
    bit [31:0] insn;
    bit [31:0] t;
    bit [31:0] n;
    bit [31:0] r;
    bit [31:0] nt;
    bit [31:0] v;
    bit [14:0] npc;
    res = '0;
    if (op == OP_LOAD) begin
      mem_img[la] = ld;
    end else begin
      insn = mem_img[cpu_pc];
      npc = cpu_pc + 15'd1;
      if (insn[31]) begin
        dsp = dsp + 5'd1;
        dstk[dsp] = cpu_t;
        cpu_t = {1'b0, insn[30:0]};
      end else begin
        case (insn[30:29])
          FORM_JUMP: npc = insn[14:0];
          FORM_CJUMP: begin
            v = cpu_t;
            cpu_t = dstk[dsp];
            dsp = dsp - 5'd1;
            if (v == 32'd0) npc = insn[14:0];
          end
          FORM_CALL: begin
            rsp = rsp + 5'd1;
            rstk[rsp] = {15'd0, npc, 2'b00};
            npc = insn[14:0];
          end
          default: begin
            t = cpu_t;
            n = dstk[dsp];
            r = rstk[rsp];
            nt = t;
            if (insn[RPC_BIT]) npc = r[16:2];
            case (insn[11:8])
              ALU_T:   nt = t;
              ALU_N:   nt = n;
              ALU_ADD: nt = t + n;
              ALU_AND: nt = t & n;
              ALU_OR:  nt = t | n;
              ALU_XOR: nt = t ^ n;
              ALU_INV: nt = ~t;
              ALU_EQ:  nt = (t == n) ? 32'hffff_ffff : 32'd0;
              ALU_SLT: nt = ($signed(n) < $signed(t)) ? 32'hffff_ffff : 32'd0;
              ALU_SHR: nt = (t < 32'd32) ? (n >> t[4:0]) : 32'd0;
              ALU_DEC: nt = t - 32'd1;
              ALU_R:   nt = r;
              ALU_LOAD: begin
                if (t == IO_STATUS) begin
                  nt = 32'd1;
                end else if (t == IO_DATA) begin
                  nt = {24'd0, rx};
                  res.rxt = 1'b1;
                end else begin
                  nt = mem_img[t[16:2]];
                end
              end
              ALU_SHL:   nt = (t < 32'd32) ? (n << t[4:0]) : 32'd0;
              ALU_DEPTH: nt = {19'd0, rsp, 3'd0, dsp};
              ALU_ULT:   nt = (n < t) ? 32'hffff_ffff : 32'd0;
              default:   nt = t;
            endcase
            dsp = dsp + ptr_step(insn[1:0]);
            rsp = rsp + ptr_step(insn[3:2]);
            if (insn[TN_BIT]) dstk[dsp] = t;
            if (insn[TR_BIT]) rstk[rsp] = t;
            // the load above already saw memory before this store
            if (insn[STORE_BIT]) begin
              if (t == IO_DATA) begin
                res.txv = 1'b1;
                res.txb = n[7:0];
              end else begin
                mem_img[t[16:2]] = n;
              end
            end
            cpu_t = nt;
          end
        endcase
      end
      cpu_pc = npc;
    end
    res.pc = cpu_pc;
    res.top = cpu_t;
    return res;
  endfunction

  function automatic bit [31:0] literal(input bit [31:0] value);
    return {1'b1, value[30:0]};
  endfunction

  function automatic bit [31:0] branch(input bit [1:0] form, input bit [28:0] target);
    return {1'b0, form, target};
  endfunction

  function automatic bit [31:0] make_alu(input bit [3:0] op, input bit rpc, input bit tn,
                                         input bit tr, input bit st, input bit [1:0] rd,
                                         input bit [1:0] dd);
    bit [31:0] w;
    w = '0;
    w[30:29] = FORM_ALU;
    w[RPC_BIT] = rpc;
    w[11:8] = op;
    w[TN_BIT] = tn;
    w[TR_BIT] = tr;
    w[STORE_BIT] = st;
    w[3:2] = rd;
    w[1:0] = dd;
    return w;
  endfunction

  function automatic bit [14:0] rand_addr();
    bit [31:0] r;
    r = $urandom();
    return r[14:0];
  endfunction

  function automatic bit [7:0] rand_byte();
    bit [31:0] r;
    r = $urandom();
    return r[7:0];
  endfunction

  function automatic bit [31:0] random_insn();
    int pick;
    bit [31:0] r;
    pick = $urandom_range(0, 99);
    r = $urandom();
    if (pick < 12) return literal(r);
    if (pick < 28) return literal($urandom_range(0, 40));
    if (pick < 32) return literal(r[0] ? 32'h0fff_ffff : 32'h0fff_fffe);
    if (pick < 42) return branch(FORM_JUMP + 2'($urandom_range(0, 2)), r[28:0]);
    return {1'b0, FORM_ALU, r[28:0]};
  endfunction

  task automatic flag_mismatch(input string what, input bit [31:0] got, input bit [31:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  // one transfer on the input channel; valid stays up so back-to-back items need no gap
  task automatic send_item(input logic op, input logic [14:0] la, input logic [31:0] ld,
                           input logic [7:0] rx);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_load_addr <= la;
    in_load_data <= ld;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(cpu_model(op, la, ld, rx));
    items_sent++;
  endtask

  // put a word at the current pc and run it
  task automatic exec_word(input bit [31:0] word);
    send_item(OP_LOAD, cpu_pc, word, rand_byte());
    send_item(OP_STEP, rand_addr(), $urandom(), rand_byte());
  endtask

  task automatic run_console_sequence();
    bit [31:0] r;
    r = $urandom();
    exec_word(literal(r[0] ? 32'h0fff_ffff : 32'h0fff_fffe));
    exec_word(make_alu(ALU_INV, 1'b0, r[1], r[2], 1'b0, DELTA_NONE, DELTA_NONE));
    exec_word(make_alu(r[3] ? ALU_LOAD : ALU_T, 1'b0, r[4], r[5], r[6], r[8:7], r[10:9]));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic test_reset_state();
    // memory is cleared, so word 0 is a jump to itself
    send_item(OP_STEP, 15'h7fff, 32'hffff_ffff, 8'hff);
    send_item(OP_LOAD, 15'h7fff, 32'hffff_ffff, 8'h00);
  endtask

  task automatic test_pc_wrap();
    exec_word(branch(FORM_JUMP, 29'h1fff_ffff));
    // top word holds the largest literal, pc rolls over to 0
    send_item(OP_STEP, 15'h0000, 32'h0000_0000, 8'h00);
  endtask

  task automatic test_call_return();
    exec_word(branch(FORM_CALL, 29'h0000_1234));
    exec_word(make_alu(ALU_R, 1'b1, 1'b0, 1'b0, 1'b0, DELTA_POP, DELTA_NONE));
    exec_word(branch(FORM_CJUMP, 29'h0000_0010));
  endtask

  task automatic test_console();
    exec_word(literal(32'h0fff_ffff));
    exec_word(make_alu(ALU_INV, 1'b0, 1'b0, 1'b0, 1'b0, DELTA_NONE, DELTA_NONE));
    // receive and transmit in one instruction
    exec_word(make_alu(ALU_LOAD, 1'b0, 1'b0, 1'b0, 1'b1, DELTA_NONE, DELTA_NONE));
    exec_word(literal(32'h0fff_fffe));
    exec_word(make_alu(ALU_INV, 1'b0, 1'b0, 1'b0, 1'b0, DELTA_NONE, DELTA_NONE));
    exec_word(make_alu(ALU_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, DELTA_NONE, DELTA_NONE));
  endtask

  task automatic test_large_shift();
    exec_word(literal(32'd32));
    exec_word(make_alu(ALU_SHL, 1'b0, 1'b0, 1'b0, 1'b0, DELTA_NONE, DELTA_POP));
  endtask

  task automatic test_full_rate();
    feed_steady = 1'b1;
    drain_steady = 1'b1;
    repeat (40) exec_word(random_insn());
    feed_steady = 1'b0;
    drain_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    // receiver holds off while items keep coming, so in_stall must rise
    feed_steady = 1'b1;
    hold_go = 1'b1;
    repeat (12) exec_word(random_insn());
    feed_steady = 1'b0;
  endtask

  task automatic test_random_programs();
    int pick;
    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 72)
        exec_word(random_insn());
      else if (pick < 80)
        run_console_sequence();
      else if (pick < 90)
        send_item(OP_STEP, rand_addr(), $urandom(), rand_byte());
      else
        send_item(OP_LOAD, rand_addr(), $urandom(), rand_byte());
    end
  endtask

  // long receiver hold, counted in cycles
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result with nothing pending, top", out_top_value, 32'd0);
      end else begin
        head_result = expected_q.pop_front();
        if (out_next_pc !== head_result.pc)
          flag_mismatch("next_pc", {17'd0, out_next_pc}, {17'd0, head_result.pc});
        if (out_top_value !== head_result.top)
          flag_mismatch("top_value", out_top_value, head_result.top);
        if (out_tx_valid !== head_result.txv)
          flag_mismatch("tx_valid", {31'd0, out_tx_valid}, {31'd0, head_result.txv});
        if (out_tx_byte !== head_result.txb)
          flag_mismatch("tx_byte", {24'd0, out_tx_byte}, {24'd0, head_result.txb});
        if (out_rx_taken !== head_result.rxt)
          flag_mismatch("rx_taken", {31'd0, out_rx_taken}, {31'd0, head_result.rxt});
      end
      sink_gap = drain_steady ? 0 : $urandom_range(0, 8);
    end
    if (sink_hold) begin
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_pc_wrap();
    test_call_return();
    test_console();
    test_large_shift();
    test_full_rate();
    test_backpressure();
    test_random_programs();
    wait_for_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
